@@ hw/rtl/descriptor_slot_allocator_macros.svh @@
// Assertion macros shared by the checker of the descriptor slot allocator.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef DESCRIPTOR_SLOT_ALLOCATOR_MACROS_SVH
`define DESCRIPTOR_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, ignored while reset is applied.
`define DSA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("descriptor slot allocator check failed");

// Next-cycle implication, ignored while reset is applied.
`define DSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("descriptor slot allocator check failed");

`endif

@@ hw/rtl/dsa_pkg.sv @@
// Shared types, codes and constants of the descriptor slot allocator.
// Used by every RTL module of the block but the checker; depends on nothing.
package dsa_pkg;

  localparam int DSA_VIEW_SLOTS   = 256;
  localparam int DSA_TARGET_SLOTS = 16;
  localparam int DSA_DEPTH_SLOTS  = 16;

  localparam int SLOT_REACH = 256;
  localparam int GROUP_W    = 16;
  localparam int GROUPS     = SLOT_REACH / GROUP_W;
  localparam int GRP_IDX_W  = $clog2(GROUP_W);

  localparam int SLOT_W   = 8;
  localparam int STRIDE_W = 16;
  localparam int PROD_W   = SLOT_W + STRIDE_W;
  localparam int ADDR_W   = 64;
  localparam int PADDR_W  = 6;
  localparam int PDATA_W  = 64;
  localparam int REG_IDX_W = 3;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd32;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    POOL_SHARED = 2'd0,
    POOL_HIDDEN = 2'd1,
    POOL_TARGET = 2'd2,
    POOL_DEPTH  = 2'd3
  } pool_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SHARED_CPU_BASE = 3'd0,
    REG_HIDDEN_CPU_BASE = 3'd1,
    REG_TARGET_CPU_BASE = 3'd2,
    REG_DEPTH_CPU_BASE  = 3'd3,
    REG_SHARED_GPU_BASE = 3'd4,
    REG_VIEW_STRIDE     = 3'd5,
    REG_TARGET_STRIDE   = 3'd6,
    REG_DEPTH_STRIDE    = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_MUL,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0]   shared_cpu_base;
    logic [ADDR_W-1:0]   hidden_cpu_base;
    logic [ADDR_W-1:0]   target_cpu_base;
    logic [ADDR_W-1:0]   depth_cpu_base;
    logic [ADDR_W-1:0]   shared_gpu_base;
    logic [STRIDE_W-1:0] view_stride;
    logic [STRIDE_W-1:0] target_stride;
    logic [STRIDE_W-1:0] depth_stride;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic scan;
    logic pick;
    logic mul;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_free;
  } ctrl_sts_t;

endpackage

@@ hw/rtl/descriptor_slot_allocator.sv @@
// Descriptor slot allocator: first-fit allocation over four used-bit maps.
// Allocate: each request steps through scan, group pick, multiply and address
// add, and the last step waits until the result register is free; the next
// request is taken while the result waits. Free: scan, then result load.
// Reset (synchronous, rst_n low) clears all maps and sets strides to 32.
module descriptor_slot_allocator #(
  parameter int VIEW_SLOTS   = dsa_pkg::DSA_VIEW_SLOTS,
  parameter int TARGET_SLOTS = dsa_pkg::DSA_TARGET_SLOTS,
  parameter int DEPTH_SLOTS  = dsa_pkg::DSA_DEPTH_SLOTS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_operation,
  input  logic [1:0]                  in_pool,
  input  logic [dsa_pkg::SLOT_W-1:0]  in_slot_to_free,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_ok,
  output logic [dsa_pkg::SLOT_W-1:0]  out_slot,
  output logic [dsa_pkg::ADDR_W-1:0]  out_cpu_address,
  output logic [dsa_pkg::ADDR_W-1:0]  out_gpu_address,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dsa_pkg::PADDR_W-1:0] paddr,
  input  logic [dsa_pkg::PDATA_W-1:0] pwdata,
  output logic [dsa_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import dsa_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  dsa_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dsa_dpath #(
    .VIEW_SLOTS   (VIEW_SLOTS),
    .TARGET_SLOTS (TARGET_SLOTS),
    .DEPTH_SLOTS  (DEPTH_SLOTS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg             (cfg),
    .in_operation    (in_operation),
    .in_pool         (in_pool),
    .in_slot_to_free (in_slot_to_free),
    .out_ok          (out_ok),
    .out_slot        (out_slot),
    .out_cpu_address (out_cpu_address),
    .out_gpu_address (out_gpu_address)
  );

endmodule

@@ hw/rtl/dsa_regs.sv @@
// Configuration register file with its APB-style access port.
// Depends on dsa_pkg for register codes and the configuration struct.
module dsa_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dsa_pkg::PADDR_W-1:0] paddr,
  input  logic [dsa_pkg::PDATA_W-1:0] pwdata,
  output logic [dsa_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output dsa_pkg::cfg_t               cfg
);
  import dsa_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  reg_e reg_idx;
  logic wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = reg_e'(paddr[PADDR_W-1:PADDR_W-REG_IDX_W]);
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_SHARED_CPU_BASE: cfg_nxt.shared_cpu_base = pwdata;
        REG_HIDDEN_CPU_BASE: cfg_nxt.hidden_cpu_base = pwdata;
        REG_TARGET_CPU_BASE: cfg_nxt.target_cpu_base = pwdata;
        REG_DEPTH_CPU_BASE:  cfg_nxt.depth_cpu_base  = pwdata;
        REG_SHARED_GPU_BASE: cfg_nxt.shared_gpu_base = pwdata;
        REG_VIEW_STRIDE:     cfg_nxt.view_stride     = pwdata[STRIDE_W-1:0];
        REG_TARGET_STRIDE:   cfg_nxt.target_stride   = pwdata[STRIDE_W-1:0];
        REG_DEPTH_STRIDE:    cfg_nxt.depth_stride    = pwdata[STRIDE_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SHARED_CPU_BASE: prdata = cfg_r.shared_cpu_base;
      REG_HIDDEN_CPU_BASE: prdata = cfg_r.hidden_cpu_base;
      REG_TARGET_CPU_BASE: prdata = cfg_r.target_cpu_base;
      REG_DEPTH_CPU_BASE:  prdata = cfg_r.depth_cpu_base;
      REG_SHARED_GPU_BASE: prdata = cfg_r.shared_gpu_base;
      REG_VIEW_STRIDE:     prdata = PDATA_W'(cfg_r.view_stride);
      REG_TARGET_STRIDE:   prdata = PDATA_W'(cfg_r.target_stride);
      REG_DEPTH_STRIDE:    prdata = PDATA_W'(cfg_r.depth_stride);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{shared_cpu_base: '0,
                 hidden_cpu_base: '0,
                 target_cpu_base: '0,
                 depth_cpu_base:  '0,
                 shared_gpu_base: '0,
                 view_stride:     STRIDE_RESET,
                 target_stride:   STRIDE_RESET,
                 depth_stride:    STRIDE_RESET};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hw/rtl/dsa_ctrl.sv @@
// Controller state machine: sequences one request through search, multiply
// and result load, and owns the result valid flag. Depends on dsa_pkg.
module dsa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  dsa_pkg::ctrl_sts_t   sts,
  output dsa_pkg::ctrl_cmd_t   cmd
);
  import dsa_pkg::*;

  state_e state_r;
  state_e state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  // The result register can take a new value once its old one is gone.
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:  state_nxt = sts.op_free ? ST_WRITE : ST_PICK;
      ST_PICK:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_WRITE;
      ST_WRITE: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_SCAN:  cmd.scan = 1'b1;
      ST_PICK:  cmd.pick = 1'b1;
      ST_MUL:   cmd.mul  = 1'b1;
      ST_WRITE: cmd.load = out_free;
      default:  cmd      = '0;
    endcase
    out_valid_nxt = cmd.load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hw/rtl/dsa_dpath.sv @@
// Datapath: the four used-bit maps, the two-level first-free search, the
// slot times stride multiplier and the result register. Depends on dsa_pkg.
module dsa_dpath #(
  parameter int VIEW_SLOTS   = dsa_pkg::DSA_VIEW_SLOTS,
  parameter int TARGET_SLOTS = dsa_pkg::DSA_TARGET_SLOTS,
  parameter int DEPTH_SLOTS  = dsa_pkg::DSA_DEPTH_SLOTS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dsa_pkg::ctrl_cmd_t         cmd,
  output dsa_pkg::ctrl_sts_t         sts,
  input  dsa_pkg::cfg_t              cfg,
  input  logic                       in_operation,
  input  logic [1:0]                 in_pool,
  input  logic [dsa_pkg::SLOT_W-1:0] in_slot_to_free,
  output logic                       out_ok,
  output logic [dsa_pkg::SLOT_W-1:0] out_slot,
  output logic [dsa_pkg::ADDR_W-1:0] out_cpu_address,
  output logic [dsa_pkg::ADDR_W-1:0] out_gpu_address
);
  import dsa_pkg::*;

  // Only the first 256 slots of a pool can be named by an 8-bit slot.
  localparam int VIEW_REACH   = (VIEW_SLOTS < SLOT_REACH) ? VIEW_SLOTS : SLOT_REACH;
  localparam int TARGET_REACH = (TARGET_SLOTS < SLOT_REACH) ? TARGET_SLOTS : SLOT_REACH;
  localparam int DEPTH_REACH  = (DEPTH_SLOTS < SLOT_REACH) ? DEPTH_SLOTS : SLOT_REACH;

  logic [VIEW_REACH-1:0]   shared_used_r, shared_used_nxt;
  logic [VIEW_REACH-1:0]   hidden_used_r, hidden_used_nxt;
  logic [TARGET_REACH-1:0] target_used_r, target_used_nxt;
  logic [DEPTH_REACH-1:0]  depth_used_r,  depth_used_nxt;

  op_e                 op_r;
  pool_e               pool_r;
  logic [SLOT_W-1:0]   req_r;

  logic [GROUPS-1:0]    grp_free_r, grp_free_nxt;
  logic [GRP_IDX_W-1:0] grp_idx_r   [GROUPS];
  logic [GRP_IDX_W-1:0] grp_idx_nxt [GROUPS];

  logic                hit_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [PROD_W-1:0]   prod_r;

  logic                  out_ok_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic [ADDR_W-1:0]     out_cpu_address_r;
  logic [ADDR_W-1:0]     out_gpu_address_r;

  logic [SLOT_REACH-1:0] busy;
  logic [GRP_IDX_W-1:0]  grp_sel;
  logic                  pick_hit;
  logic [SLOT_W-1:0]     pick_slot;
  logic                  free_in_range;
  logic [STRIDE_W-1:0]   stride_sel;
  logic [ADDR_W-1:0]     base_sel;
  logic                  set_en;
  logic                  clr_en;

  assign sts.op_free     = (op_r == OP_FREE);
  assign out_ok          = out_ok_r;
  assign out_slot        = out_slot_r;
  assign out_cpu_address = out_cpu_address_r;
  assign out_gpu_address = out_gpu_address_r;

  // Map of the selected pool, with slots beyond the pool shown as taken.
  always_comb begin
    busy = '1;
    unique case (pool_r)
      POOL_SHARED: busy[VIEW_REACH-1:0]   = shared_used_r;
      POOL_HIDDEN: busy[VIEW_REACH-1:0]   = hidden_used_r;
      POOL_TARGET: busy[TARGET_REACH-1:0] = target_used_r;
      POOL_DEPTH:  busy[DEPTH_REACH-1:0]  = depth_used_r;
      default:     busy = '1;
    endcase
  end

  // First search level: per group, whether a slot is free and which is lowest.
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_free_nxt[g] = ~&busy[g*GROUP_W +: GROUP_W];
      grp_idx_nxt[g]  = '0;
      for (int b = GROUP_W - 1; b >= 0; b--) begin
        if (!busy[g*GROUP_W + b]) grp_idx_nxt[g] = GRP_IDX_W'(b);
      end
    end
  end

  // Second search level: lowest group that has a free slot.
  always_comb begin
    grp_sel = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_free_r[g]) grp_sel = GRP_IDX_W'(g);
    end
    pick_hit  = |grp_free_r;
    pick_slot = {grp_sel, grp_idx_r[grp_sel]};
  end

  always_comb begin
    unique case (pool_r)
      POOL_SHARED: begin
        free_in_range = 32'(req_r) < 32'(VIEW_SLOTS);
        stride_sel    = cfg.view_stride;
        base_sel      = cfg.shared_cpu_base;
      end
      POOL_HIDDEN: begin
        free_in_range = 32'(req_r) < 32'(VIEW_SLOTS);
        stride_sel    = cfg.view_stride;
        base_sel      = cfg.hidden_cpu_base;
      end
      POOL_TARGET: begin
        free_in_range = 32'(req_r) < 32'(TARGET_SLOTS);
        stride_sel    = cfg.target_stride;
        base_sel      = cfg.target_cpu_base;
      end
      POOL_DEPTH: begin
        free_in_range = 32'(req_r) < 32'(DEPTH_SLOTS);
        stride_sel    = cfg.depth_stride;
        base_sel      = cfg.depth_cpu_base;
      end
      default: begin
        free_in_range = 1'b0;
        stride_sel    = '0;
        base_sel      = '0;
      end
    endcase
  end

  assign set_en = cmd.pick && pick_hit;
  assign clr_en = cmd.load && (op_r == OP_FREE) && free_in_range;

  always_comb begin
    shared_used_nxt = shared_used_r;
    hidden_used_nxt = hidden_used_r;
    target_used_nxt = target_used_r;
    depth_used_nxt  = depth_used_r;
    for (int j = 0; j < VIEW_REACH; j++) begin
      if (pool_r == POOL_SHARED && set_en && pick_slot == SLOT_W'(j))
        shared_used_nxt[j] = 1'b1;
      if (pool_r == POOL_SHARED && clr_en && req_r == SLOT_W'(j))
        shared_used_nxt[j] = 1'b0;
      if (pool_r == POOL_HIDDEN && set_en && pick_slot == SLOT_W'(j))
        hidden_used_nxt[j] = 1'b1;
      if (pool_r == POOL_HIDDEN && clr_en && req_r == SLOT_W'(j))
        hidden_used_nxt[j] = 1'b0;
    end
    for (int j = 0; j < TARGET_REACH; j++) begin
      if (pool_r == POOL_TARGET && set_en && pick_slot == SLOT_W'(j))
        target_used_nxt[j] = 1'b1;
      if (pool_r == POOL_TARGET && clr_en && req_r == SLOT_W'(j))
        target_used_nxt[j] = 1'b0;
    end
    for (int j = 0; j < DEPTH_REACH; j++) begin
      if (pool_r == POOL_DEPTH && set_en && pick_slot == SLOT_W'(j))
        depth_used_nxt[j] = 1'b1;
      if (pool_r == POOL_DEPTH && clr_en && req_r == SLOT_W'(j))
        depth_used_nxt[j] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shared_used_r <= '0;
      hidden_used_r <= '0;
      target_used_r <= '0;
      depth_used_r  <= '0;
    end else begin
      shared_used_r <= shared_used_nxt;
      hidden_used_r <= hidden_used_nxt;
      target_used_r <= target_used_nxt;
      depth_used_r  <= depth_used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= op_e'(in_operation);
      pool_r <= pool_e'(in_pool);
      req_r  <= in_slot_to_free;
    end
    if (cmd.scan) begin
      grp_free_r <= grp_free_nxt;
      grp_idx_r  <= grp_idx_nxt;
    end
    if (cmd.pick) begin
      hit_r  <= pick_hit;
      slot_r <= pick_slot;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(slot_r) * PROD_W'(stride_sel);
    end
    if (cmd.load) begin
      if (op_r == OP_FREE) begin
        out_ok_r          <= free_in_range;
        out_slot_r        <= req_r;
        out_cpu_address_r <= '0;
        out_gpu_address_r <= '0;
      end else if (hit_r) begin
        out_ok_r          <= 1'b1;
        out_slot_r        <= slot_r;
        out_cpu_address_r <= base_sel + ADDR_W'(prod_r);
        out_gpu_address_r <= (pool_r == POOL_SHARED) ?
                             cfg.shared_gpu_base + ADDR_W'(prod_r) : '0;
      end else begin
        out_ok_r          <= 1'b0;
        out_slot_r        <= '0;
        out_cpu_address_r <= '0;
        out_gpu_address_r <= '0;
      end
    end
  end

endmodule

@@ hw/rtl/dsa_checker.sv @@
// Port-level checker for the descriptor slot allocator, bound to the top.
// Depends on descriptor_slot_allocator_macros.svh for the assertion macros.
`include "descriptor_slot_allocator_macros.svh"

module dsa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_ok,
  input logic [63:0] out_cpu_address,
  input logic [63:0] out_gpu_address,
  input logic        pready
);

  // Only one request is in flight, so acceptance closes the input.
  `DSA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  // A refused request carries no addresses.
  `DSA_ASSERT_NOW(a_refused_no_addr, out_valid && !out_ok,
                  out_cpu_address == 64'd0 && out_gpu_address == 64'd0)
  // A shader-visible address only comes with a granted slot.
  `DSA_ASSERT_NOW(a_gpu_needs_ok, out_valid && out_gpu_address != 64'd0, out_ok)
  // A waiting result stays in place.
  `DSA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_cpu_address) && $stable(out_ok))
  `DSA_ASSERT_NOW(a_cfg_ready, 1'b1, pready)

endmodule

bind descriptor_slot_allocator dsa_checker u_dsa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_ok          (out_ok),
  .out_cpu_address (out_cpu_address),
  .out_gpu_address (out_gpu_address),
  .pready          (pready)
);

@@ bench/dsa_grant_checker.sv @@
// Scoreboard for the descriptor slot allocator: watches the request, result and
// register ports, keeps its own copy of the used-bit maps and pool settings.
// Depends on dsa_pkg for the operation, pool and register codes.
module dsa_grant_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        in_operation,
  input  logic [1:0]                  in_pool,
  input  logic [dsa_pkg::SLOT_W-1:0]  in_slot_to_free,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        out_ok,
  input  logic [dsa_pkg::SLOT_W-1:0]  out_slot,
  input  logic [dsa_pkg::ADDR_W-1:0]  out_cpu_address,
  input  logic [dsa_pkg::ADDR_W-1:0]  out_gpu_address,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dsa_pkg::PADDR_W-1:0] paddr,
  input  logic [dsa_pkg::PDATA_W-1:0] pwdata,
  input  logic                        pready,
  output int                          mismatch_count,
  output int                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import dsa_pkg::*;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] cpu_address;
    logic [ADDR_W-1:0] gpu_address;
  } grant_t;

  grant_t                       expected_grants[$];
  cfg_t                         pool_cfg;
  logic [DSA_VIEW_SLOTS-1:0]    shared_used;
  logic [DSA_VIEW_SLOTS-1:0]    hidden_used;
  logic [DSA_TARGET_SLOTS-1:0]  target_used;
  logic [DSA_DEPTH_SLOTS-1:0]   depth_used;
  int                           faults;

  // Works out the answer to one request and updates the chosen used-bit map.
  function automatic grant_t predict_grant(input op_e op, input pool_e pool,
                                           input logic [SLOT_W-1:0] req);
    grant_t                g;
    logic [SLOT_REACH-1:0] map;
    int                    size;
    logic [ADDR_W-1:0]     base;
    logic [STRIDE_W-1:0]   stride;
    int                    i;
    bit                    found;
    g = '0;
    found = 1'b0;
    map = '0;
    case (pool)
      POOL_SHARED: begin
        map[DSA_VIEW_SLOTS-1:0] = shared_used;
        size = DSA_VIEW_SLOTS;
        base = pool_cfg.shared_cpu_base;
        stride = pool_cfg.view_stride;
      end
      POOL_HIDDEN: begin
        map[DSA_VIEW_SLOTS-1:0] = hidden_used;
        size = DSA_VIEW_SLOTS;
        base = pool_cfg.hidden_cpu_base;
        stride = pool_cfg.view_stride;
      end
      POOL_TARGET: begin
        map[DSA_TARGET_SLOTS-1:0] = target_used;
        size = DSA_TARGET_SLOTS;
        base = pool_cfg.target_cpu_base;
        stride = pool_cfg.target_stride;
      end
      default: begin
        map[DSA_DEPTH_SLOTS-1:0] = depth_used;
        size = DSA_DEPTH_SLOTS;
        base = pool_cfg.depth_cpu_base;
        stride = pool_cfg.depth_stride;
      end
    endcase

    if (op == OP_FREE) begin
      // Freeing a slot that is already free still counts as a success.
      g.slot = req;
      if (int'(req) < size) begin
        map[req] = 1'b0;
        g.ok = 1'b1;
      end
    end else begin
      for (i = 0; i < size && i < SLOT_REACH; i++) begin
        if (!found && !map[i]) begin
          found = 1'b1;
          map[i] = 1'b1;
          g.ok = 1'b1;
          g.slot = SLOT_W'(i);
          g.cpu_address = base + ADDR_W'(i) * ADDR_W'(stride);
          if (pool == POOL_SHARED)
            g.gpu_address = pool_cfg.shared_gpu_base
                            + ADDR_W'(i) * ADDR_W'(pool_cfg.view_stride);
        end
      end
    end

    case (pool)
      POOL_SHARED: shared_used = map[DSA_VIEW_SLOTS-1:0];
      POOL_HIDDEN: hidden_used = map[DSA_VIEW_SLOTS-1:0];
      POOL_TARGET: target_used = map[DSA_TARGET_SLOTS-1:0];
      default:     depth_used = map[DSA_DEPTH_SLOTS-1:0];
    endcase
    return g;
  endfunction

  always @(posedge clk) begin : watch
    grant_t want;
    if (!rst_n) begin
      pool_cfg = '0;
      pool_cfg.view_stride = STRIDE_RESET;
      pool_cfg.target_stride = STRIDE_RESET;
      pool_cfg.depth_stride = STRIDE_RESET;
      shared_used = '0;
      hidden_used = '0;
      target_used = '0;
      depth_used = '0;
      expected_grants.delete();
      faults = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_e'(paddr[PADDR_W-1:3]))
          REG_SHARED_CPU_BASE: pool_cfg.shared_cpu_base = pwdata;
          REG_HIDDEN_CPU_BASE: pool_cfg.hidden_cpu_base = pwdata;
          REG_TARGET_CPU_BASE: pool_cfg.target_cpu_base = pwdata;
          REG_DEPTH_CPU_BASE:  pool_cfg.depth_cpu_base = pwdata;
          REG_SHARED_GPU_BASE: pool_cfg.shared_gpu_base = pwdata;
          REG_VIEW_STRIDE:     pool_cfg.view_stride = pwdata[STRIDE_W-1:0];
          REG_TARGET_STRIDE:   pool_cfg.target_stride = pwdata[STRIDE_W-1:0];
          REG_DEPTH_STRIDE:    pool_cfg.depth_stride = pwdata[STRIDE_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready)
        expected_grants.push_back(predict_grant(op_e'(in_operation), pool_e'(in_pool),
                                                in_slot_to_free));

      if (out_valid && out_ready) begin
        if (expected_grants.size() == 0) begin
          if (faults < 10)
            $display("ERROR: result with none pending: ok=%0d slot=%0d cpu=%h gpu=%h",
                     out_ok, out_slot, out_cpu_address, out_gpu_address);
          faults++;
        end else begin
          want = expected_grants.pop_front();
          if (out_ok !== want.ok || out_slot !== want.slot ||
              out_cpu_address !== want.cpu_address ||
              out_gpu_address !== want.gpu_address) begin
            if (faults < 10) begin
              $display("ERROR: expected ok=%0d slot=%0d cpu=%h gpu=%h",
                       want.ok, want.slot, want.cpu_address, want.gpu_address);
              $display("       got      ok=%0d slot=%0d cpu=%h gpu=%h",
                       out_ok, out_slot, out_cpu_address, out_gpu_address);
            end
            faults++;
          end
        end
      end
    end
    mismatch_count <= faults;
    outstanding <= expected_grants.size();
  end

endmodule

@@ bench/tb.sv @@
// Top of the descriptor slot allocator bench: clock, reset, requests, register
// writes and the verdict. Depends on dsa_pkg, the block and dsa_grant_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dsa_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 300;
  localparam int PHASES      = 5;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_operation = 1'b0;
  logic [1:0]         in_pool = '0;
  logic [SLOT_W-1:0]  in_slot_to_free = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_ok;
  logic [SLOT_W-1:0]  out_slot;
  logic [ADDR_W-1:0]  out_cpu_address;
  logic [ADDR_W-1:0]  out_gpu_address;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 mismatch_count;
  int                 outstanding;
  int                 cycles = 0;
  int                 stall_pct = 0;
  int                 gap_pct = 0;

  // Per phase: share of allocations, favoured pool and how often it is picked.
  int    alloc_pct_of[PHASES] = '{60, 98, 98, 35, 70};
  pool_e favoured_of[PHASES]  = '{POOL_SHARED, POOL_SHARED, POOL_HIDDEN, POOL_TARGET,
                                  POOL_DEPTH};
  int    favour_pct_of[PHASES] = '{0, 90, 90, 30, 30};

  descriptor_slot_allocator u_dut (.*);
  dsa_grant_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= stall_pct);

  task automatic write_register(input reg_e idx, input logic [PDATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 3'b000});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic send_request(input op_e op, input pool_e pool,
                              input logic [SLOT_W-1:0] slot);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_pool <= pool;
    in_slot_to_free <= slot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Lowers valid, then waits until every pending result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_setting(input int setting);
    logic [ADDR_W-1:0]   bases[5];
    logic [STRIDE_W-1:0] strides[3];
    logic [PDATA_W-1:0]  upper;
    int                  i;
    for (i = 0; i < 5; i++) begin
      case (setting)
        1:       bases[i] = '1;
        2:       bases[i] = '0;
        default: bases[i] = {$urandom, $urandom};
      endcase
    end
    for (i = 0; i < 3; i++) begin
      case (setting)
        1:       strides[i] = '1;
        2:       strides[i] = '0;
        3:       strides[i] = 16'd1;
        default: strides[i] = 16'($urandom_range(65535));
      endcase
    end
    // Bits above the stride width are junk that the block should drop.
    upper = {$urandom, $urandom};
    write_register(REG_SHARED_CPU_BASE, bases[0]);
    write_register(REG_HIDDEN_CPU_BASE, bases[1]);
    write_register(REG_TARGET_CPU_BASE, bases[2]);
    write_register(REG_DEPTH_CPU_BASE, bases[3]);
    write_register(REG_SHARED_GPU_BASE, bases[4]);
    write_register(REG_VIEW_STRIDE, {upper[PDATA_W-1:STRIDE_W], strides[0]});
    write_register(REG_TARGET_STRIDE, {upper[PDATA_W-1:STRIDE_W], strides[1]});
    write_register(REG_DEPTH_STRIDE, {upper[PDATA_W-1:STRIDE_W], strides[2]});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_request(input int alloc_pct, input pool_e favoured,
                                input int favour_pct);
    pool_e             pool;
    int                slots;
    logic [SLOT_W-1:0] slot;
    if ($urandom_range(99) < favour_pct)
      pool = favoured;
    else
      pool = pool_e'($urandom_range(3));
    slots = (pool == POOL_TARGET) ? DSA_TARGET_SLOTS :
            (pool == POOL_DEPTH) ? DSA_DEPTH_SLOTS : DSA_VIEW_SLOTS;
    if ($urandom_range(99) < alloc_pct) begin
      send_request(OP_ALLOC, pool, SLOT_W'($urandom_range(255)));
    end else begin
      // Mostly slots inside the pool, so that used slots are released.
      if ($urandom_range(99) < 80)
        slot = SLOT_W'($urandom_range(slots - 1));
      else
        slot = SLOT_W'($urandom_range(255));
      send_request(OP_FREE, pool, slot);
    end
  endtask

  initial begin : stimulus
    int i;
    int phase;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests under the reset settings.
    send_request(OP_ALLOC, POOL_SHARED, 8'hFF);
    send_request(OP_ALLOC, POOL_HIDDEN, 8'h00);
    send_request(OP_ALLOC, POOL_TARGET, 8'hA5);
    // Fill the depth pool; the last request finds it full.
    for (i = 0; i <= DSA_DEPTH_SLOTS; i++)
      send_request(OP_ALLOC, POOL_DEPTH, SLOT_W'(i));
    send_request(OP_FREE, POOL_DEPTH, SLOT_W'(DSA_DEPTH_SLOTS - 1));
    send_request(OP_FREE, POOL_DEPTH, SLOT_W'(DSA_DEPTH_SLOTS - 1));
    send_request(OP_FREE, POOL_DEPTH, SLOT_W'(DSA_DEPTH_SLOTS));
    send_request(OP_FREE, POOL_TARGET, 8'hFF);
    send_request(OP_FREE, POOL_SHARED, 8'hFF);
    send_request(OP_ALLOC, POOL_DEPTH, 8'h00);
    send_request(OP_FREE, POOL_HIDDEN, 8'h00);

    for (phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      apply_setting(phase);
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct <= 0;  end
        1: begin gap_pct = 48; stall_pct <= 0;  end
        2: begin gap_pct = 0;  stall_pct <= 48; end
        default: begin gap_pct = 32; stall_pct <= 32; end
      endcase
      for (i = 0; i < PHASE_ITEMS; i++)
        random_request(alloc_pct_of[phase], favoured_of[phase], favour_pct_of[phase]);
    end

    wait_drained();
    if (mismatch_count == 0 && outstanding == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
